// ----- hw/rtl/tpmq_pkg.sv -----
// Shared package for the tree path maximum query block.
// Holds payload structs, action codes and parameter defaults; depends on nothing.
package tpmq_pkg;

  localparam int NODES_DEF       = 1023;
  localparam int LEVELS_DEF      = 10;
  localparam int WEIGHT_BITS_DEF = 20;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  node;
    logic [9:0]  parent_node;
    logic [19:0] edge_weight;
    logic [9:0]  node_depth;
    logic [9:0]  second_node;
  } in_t;

  typedef struct packed {
    logic [19:0] max_edge;
    logic [9:0]  common_ancestor;
  } out_t;

endpackage

// ----- hw/rtl/tpmq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for every table of the path query block.
module tpmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tree_path_max_edge_query.sv -----
// Top level of the tree path maximum query block (binary lifting).
// Depends on tpmq_pkg and tpmq_ram.
//
// Usage: the host writes node_count over the APB-style port, then sends
// transactions on the input channel (in_valid/in_ready, payload in_data).
// A load transaction stores one node's parent, edge weight and depth. A
// build transaction fills the doubling tables for levels 1 to LEVELS-1. A
// query transaction returns the lowest common ancestor of two nodes and the
// largest edge weight on the path between them. Every transaction produces
// exactly one result on the output channel (out_valid/out_ready, out_data).
// The block works on one transaction at a time; its speed is set by the
// single read port of the lifting table, one dependent read per step.
// After reset the block sweeps both memories to zero, one entry per cycle;
// in_ready stays low meanwhile, while configuration writes are taken as
// ever.
// The output register holds a finished result while the receiver stalls;
// the next transaction may be accepted and worked on in the meantime, and
// it waits for the register to free before its result is presented.
module tree_path_max_edge_query #(
  parameter int NODES       = tpmq_pkg::NODES_DEF,
  parameter int LEVELS      = tpmq_pkg::LEVELS_DEF,
  parameter int WEIGHT_BITS = tpmq_pkg::WEIGHT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tpmq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tpmq_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int NB    = $clog2(NODES + 1);
  localparam int LB    = $clog2(LEVELS);
  localparam int KB    = $clog2(LEVELS + 1);
  localparam int WB    = WEIGHT_BITS;
  localparam int AW    = LB + NB;
  localparam int LDEPTH = LEVELS << NB;
  localparam int LW    = NB + WB;
  localparam int DW    = 10;

  localparam logic [4:0] S_IDLE = 5'd0,  S_CLR  = 5'd1,  S_LOAD = 5'd2,  S_Q0   = 5'd3;
  localparam logic [4:0] S_Q1   = 5'd4,  S_Q2   = 5'd5,  S_QL   = 5'd6,  S_QLW  = 5'd7;
  localparam logic [4:0] S_QC   = 5'd8,  S_QC1  = 5'd9,  S_QC2  = 5'd10, S_QF   = 5'd11;
  localparam logic [4:0] S_QF1  = 5'd12, S_QD   = 5'd13, S_QS   = 5'd14, S_QS1  = 5'd15;
  localparam logic [4:0] S_QM   = 5'd16, S_QMW  = 5'd17, S_BA   = 5'd18, S_BB   = 5'd19;
  localparam logic [4:0] S_BC   = 5'd20, S_DONE = 5'd21, S_B0   = 5'd22;

  localparam logic [AW-1:0] CLR_LAST = {LB'(LEVELS - 1), {NB{1'b1}}};
  localparam logic [KB-1:0] K_END    = KB'(LEVELS);
  localparam logic [KB-1:0] K_TOP    = KB'(LEVELS - 1);
  localparam logic [16:0]   NODES17  = 17'(NODES);

  // Configuration register.
  logic [9:0] node_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
  assign prdata = (paddr == 3'd0) ? {22'd0, node_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 10'd1;
    end else if (cfg_wr) begin
      node_count <= pwdata[9:0];
    end
  end

  // Active range and input conversion.
  logic [16:0]   active17;
  logic [NB-1:0] in_p, in_q, in_par;
  logic [16:0]   node17, second17, par17;
  logic [31:0]   weight32;

  assign active17 = ({7'd0, node_count} > NODES17) ? NODES17 : {7'd0, node_count};
  assign node17   = {7'd0, in_data.node};
  assign second17 = {7'd0, in_data.second_node};
  assign par17    = {7'd0, in_data.parent_node};
  assign in_p     = (node17 != 17'd0 && node17 <= active17) ? node17[NB-1:0] : '0;
  assign in_q     = (second17 != 17'd0 && second17 <= active17) ? second17[NB-1:0] : '0;
  assign in_par   = (par17 > NODES17) ? '0 : par17[NB-1:0];
  assign weight32 = {12'd0, in_data.edge_weight};

  // Sequencer registers.
  logic [4:0]        state;
  logic [AW-1:0]     clr;
  logic [NB-1:0]     p, q, p0, q0, cur, ap, anc, cnt, j, par;
  logic [WB-1:0]     weight, best, m;
  logic [DW-1:0]     ndepth, dp, da;
  logic [LEVELS-1:0] steps;
  logic [KB-1:0]     k;
  logic              side;

  // Memory ports.
  logic              l_we, d_we;
  logic [AW-1:0]     l_waddr, l_raddr;
  logic [LW-1:0]     l_wdata, l_rdata;
  logic [NB-1:0]     d_waddr, d_raddr;
  logic [DW-1:0]     d_wdata, d_rdata;
  logic [NB-1:0]     rd_anc;
  logic [WB-1:0]     rd_pm;
  logic [KB-1:0]     km1;
  logic [DW-1:0]     diff;
  logic [16:0]       diff17;

  assign rd_anc = l_rdata[LW-1:WB];
  assign rd_pm  = l_rdata[WB-1:0];
  assign km1    = k - KB'(1);

  tpmq_ram #(.WIDTH(LW), .DEPTH(LDEPTH)) u_lift_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  tpmq_ram #(.WIDTH(DW), .DEPTH(1 << NB)) u_depth_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  // Write ports: clearing sweep, node load, and table build.
  always_comb begin
    l_we    = 1'b0;
    l_waddr = {LB'(0), p};
    l_wdata = {par, weight};
    d_we    = 1'b0;
    d_waddr = p;
    d_wdata = ndepth;
    unique case (state)
      S_CLR: begin
        l_we    = 1'b1;
        l_waddr = clr;
        l_wdata = '0;
        d_we    = (clr[AW-1:NB] == '0);
        d_waddr = clr[NB-1:0];
        d_wdata = '0;
      end
      S_LOAD: begin
        l_we = (p != '0);
        d_we = (p != '0);
      end
      S_BC: begin
        l_we    = 1'b1;
        l_waddr = {k[LB-1:0], j};
        l_wdata = {rd_anc, (rd_pm > m) ? rd_pm : m};
      end
      default: begin
      end
    endcase
  end

  // Read addresses, one per state that issues a read.
  always_comb begin
    l_raddr = {k[LB-1:0], p};
    d_raddr = p;
    unique case (state)
      S_Q1:          d_raddr = q;
      S_QD:          d_raddr = anc;
      S_QS:          d_raddr = cur;
      S_QM: begin
        d_raddr = q0;
        l_raddr = {k[LB-1:0], cur};
      end
      S_QC1:         l_raddr = {k[LB-1:0], q};
      S_QF:          l_raddr = {LB'(0), p};
      S_QS1:         l_raddr = {k[LB-1:0], cur};
      S_BA:          l_raddr = {km1[LB-1:0], j};
      S_BB:          l_raddr = {km1[LB-1:0], rd_anc};
      default: begin
      end
    endcase
  end

  // Depth difference of the node at the read port against the reference.
  always_comb begin
    diff   = d_rdata - ((state == S_Q2) ? dp : da);
    diff17 = {7'd0, diff};
    if (state == S_Q2 && d_rdata > dp) begin
      diff   = d_rdata - dp;
      diff17 = {7'd0, diff};
    end else if (state == S_Q2) begin
      diff   = dp - d_rdata;
      diff17 = {7'd0, diff};
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr <= clr + AW'(1);
          if (clr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            best   <= '0;
            anc    <= '0;
            p      <= (in_data.action == tpmq_pkg::ACT_QUERY) ? in_p :
                      (in_data.action == tpmq_pkg::ACT_LOAD) ? in_p : '0;
            q      <= in_q;
            p0     <= in_p;
            q0     <= in_q;
            par    <= in_par;
            weight <= weight32[WB-1:0];
            ndepth <= in_data.node_depth;
            cnt    <= active17[NB-1:0];
            unique case (in_data.action)
              tpmq_pkg::ACT_LOAD:  state <= S_LOAD;
              tpmq_pkg::ACT_BUILD: state <= S_B0;
              tpmq_pkg::ACT_QUERY: state <= S_Q0;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_LOAD: state <= S_DONE;
        // Query: fetch both depths and order the pair, deeper node first.
        S_Q0: state <= S_Q1;
        S_Q1: begin
          dp    <= d_rdata;
          state <= S_Q2;
        end
        S_Q2: begin
          if (dp < d_rdata) begin
            p <= q;
            q <= p;
          end
          steps <= (dp != d_rdata) ? diff17[LEVELS-1:0] : '0;
          k     <= '0;
          state <= S_QL;
        end
        // Lift the deeper node by the depth difference, one set bit per read.
        S_QL: begin
          if (k == K_END) begin
            k     <= K_TOP;
            state <= S_QC;
          end else if (steps[k[LB-1:0]]) begin
            state <= S_QLW;
          end else begin
            k <= k + KB'(1);
          end
        end
        S_QLW: begin
          p     <= rd_anc;
          k     <= k + KB'(1);
          state <= S_QL;
        end
        // Lift both nodes while their ancestors at level k differ.
        S_QC: state <= S_QC1;
        S_QC1: begin
          ap    <= rd_anc;
          state <= S_QC2;
        end
        S_QC2: begin
          if (ap != rd_anc) begin
            p <= ap;
            q <= rd_anc;
          end
          if (k == '0) begin
            state <= S_QF;
          end else begin
            k     <= km1;
            state <= S_QC;
          end
        end
        S_QF: begin
          if (p == q) begin
            anc   <= p;
            state <= S_QD;
          end else begin
            state <= S_QF1;
          end
        end
        S_QF1: begin
          anc   <= rd_anc;
          state <= S_QD;
        end
        // Walk each original node up to the ancestor, collecting the maximum.
        S_QD: begin
          side  <= 1'b0;
          cur   <= p0;
          state <= S_QS;
        end
        S_QS: begin
          da    <= d_rdata;
          state <= S_QS1;
        end
        S_QS1: begin
          steps <= (d_rdata > da) ? diff17[LEVELS-1:0] : '0;
          k     <= '0;
          state <= S_QM;
        end
        S_QM: begin
          if (k == K_END) begin
            if (!side) begin
              side  <= 1'b1;
              cur   <= q0;
              state <= S_QS1;
            end else begin
              state <= S_DONE;
            end
          end else if (steps[k[LB-1:0]]) begin
            state <= S_QMW;
          end else begin
            k <= k + KB'(1);
          end
        end
        S_QMW: begin
          if (rd_pm > best) begin
            best <= rd_pm;
          end
          cur   <= rd_anc;
          k     <= k + KB'(1);
          state <= S_QM;
        end
        // Build: level k row j from level k-1 rows j and its ancestor.
        S_B0: begin
          k     <= KB'(1);
          j     <= NB'(1);
          state <= (cnt == '0) ? S_DONE : S_BA;
        end
        S_BA: state <= S_BB;
        S_BB: begin
          m     <= rd_pm;
          state <= S_BC;
        end
        S_BC: begin
          if (j == cnt) begin
            j <= NB'(1);
            if (k == K_TOP) begin
              state <= S_DONE;
            end else begin
              k     <= k + KB'(1);
              state <= S_BA;
            end
          end else begin
            j     <= j + NB'(1);
            state <= S_BA;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload, loaded as the transaction completes.
  logic [31:0] best32;
  logic [16:0] anc17;
  assign best32 = {{(32 - WB){1'b0}}, best};
  assign anc17  = {{(17 - NB){1'b0}}, anc};

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.max_edge        <= best32[19:0];
      out_data.common_ancestor <= anc17[9:0];
    end
  end

endmodule
